// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on clk, disabled while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Assert a property on clk that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: sv/tjfk_pkg.sv
// Package for the three-joint arm forward kinematics block.
// Holds register indexes, CORDIC constants and the link register struct.
package tjfk_pkg;
	localparam int CORDIC_STAGES = 30;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	typedef enum logic [2:0] {
		REG_BASE_OFFSET     = 3'd0,
		REG_SHOULDER_OFFSET = 3'd1,
		REG_BASE_HEIGHT     = 3'd2,
		REG_SHOULDER_HEIGHT = 3'd3,
		REG_UPPER_ARM       = 3'd4,
		REG_FOREARM         = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] l1;
		logic [15:0] l2;
		logic [15:0] l3;
		logic [15:0] l4;
		logic [15:0] l5;
		logic [15:0] l6;
	} links_t;

	function automatic logic signed [33:0] atan_entry(input int i);
		logic signed [33:0] t;
		case (i)
			0:  t = 34'sh20000000;
			1:  t = 34'sh12E4051D;
			2:  t = 34'sh09FB385B;
			3:  t = 34'sh051111D4;
			4:  t = 34'sh028B0D43;
			5:  t = 34'sh0145D7E1;
			6:  t = 34'sh00A2F61E;
			7:  t = 34'sh00517C55;
			8:  t = 34'sh0028BE53;
			9:  t = 34'sh00145F2E;
			10: t = 34'sh000A2F98;
			11: t = 34'sh000517CC;
			12: t = 34'sh00028BE6;
			13: t = 34'sh000145F3;
			14: t = 34'sh0000A2F9;
			15: t = 34'sh0000517C;
			16: t = 34'sh000028BE;
			17: t = 34'sh0000145F;
			18: t = 34'sh00000A2F;
			19: t = 34'sh00000517;
			20: t = 34'sh0000028B;
			21: t = 34'sh00000145;
			22: t = 34'sh000000A2;
			23: t = 34'sh00000051;
			24: t = 34'sh00000028;
			25: t = 34'sh00000014;
			26: t = 34'sh0000000A;
			27: t = 34'sh00000005;
			28: t = 34'sh00000002;
			29: t = 34'sh00000001;
			default: t = '0;
		endcase
		return t;
	endfunction
endpackage

// File: sv/three_joint_arm_forward_kinematics.sv
// Top level of the three-joint arm forward kinematics block.
// Uses tjfk_pkg, tjfk_cordic and tjfk_combine.
//
// Takes one word of three 16-bit joint angles per cycle, unless the output
// stalls, and returns the end-effector position (x, y, z, signed Q7.16).
// Three parallel CORDIC pipelines (an input register and 30 rotation stages)
// give sin/cos of yaw, shoulder and shoulder+elbow, then four arithmetic
// stages apply the six link lengths. The whole pipeline advances only when
// the output register is free or being taken, so a stall loses nothing. The
// user must write link lengths through the cfg port only while the block is
// idle, which the block itself does not enforce; an index beyond five is dropped.
module three_joint_arm_forward_kinematics #(
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // yaw_angle, shoulder_angle, elbow_angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // pos_x, pos_y, pos_z
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import tjfk_pkg::*;
	localparam int LAT = CORDIC_STAGES + 5;

	links_t links_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			links_q <= '{16'd4096, 16'd410, 16'd410, 16'd410, 16'd4096, 16'd410};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_BASE_OFFSET:     links_q.l1 <= cfg_data;
				REG_SHOULDER_OFFSET: links_q.l2 <= cfg_data;
				REG_BASE_HEIGHT:     links_q.l3 <= cfg_data;
				REG_SHOULDER_HEIGHT: links_q.l4 <= cfg_data;
				REG_UPPER_ARM:       links_q.l5 <= cfg_data;
				REG_FOREARM:         links_q.l6 <= cfg_data;
				default: ;
			endcase
		end
	end
	assign cfg_ready = 1'b1;

	// advance everything when the last stage is empty or being drained
	logic en;
	logic [LAT-1:0] vld_q;
	assign en       = !vld_q[LAT-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	logic [15:0] sum_ang;
	assign sum_ang = s_tdata[31:16] + s_tdata[47:32];

	logic signed [TRIG_FRAC_BITS+1:0] sa, ca, sb, cb, ss, cs;
	tjfk_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yaw (
		.clk(clk), .en(en), .angle(s_tdata[15:0]), .sin_o(sa), .cos_o(ca));
	tjfk_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sh (
		.clk(clk), .en(en), .angle(s_tdata[31:16]), .sin_o(sb), .cos_o(cb));
	tjfk_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_sum (
		.clk(clk), .en(en), .angle(sum_ang), .sin_o(ss), .cos_o(cs));

	logic [23:0] px, py, pz;
	tjfk_combine #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_comb (
		.clk(clk), .en(en), .links(links_q),
		.sa(sa), .ca(ca), .sb(sb), .cb(cb), .ss(ss), .cs(cs),
		.pos_x(px), .pos_y(py), .pos_z(pz));

	assign m_tdata = {pz, py, px};
endmodule

// File: sv/tjfk_cordic.sv
// Pipelined rotation-mode CORDIC: one stage per register, one angle per cycle while en is high.
// Depends on tjfk_pkg for the arctangent table and gain.
module tjfk_cordic #(
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [15:0]                 angle,
	output logic signed [TRIG_FRAC_BITS+1:0] sin_o,
	output logic signed [TRIG_FRAC_BITS+1:0] cos_o
);
	import tjfk_pkg::*;
	localparam int N = CORDIC_STAGES;
	localparam int SH = 30 - TRIG_FRAC_BITS;

	logic signed [33:0] x_s [0:N];
	logic signed [33:0] y_s [0:N];
	logic signed [33:0] th_s [0:N];
	logic               neg_s [0:N];

	logic signed [33:0] th0;
	logic               neg0;
	always_comb begin
		th0  = {{2{angle[15]}}, angle, 16'd0};
		neg0 = 1'b0;
		if (th0 > 34'sh40000000) begin
			th0  = th0 - 34'sh80000000;
			neg0 = 1'b1;
		end else if (th0 < -34'sh40000000) begin
			th0  = th0 + 34'sh80000000;
			neg0 = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]   <= CORDIC_GAIN;
			y_s[0]   <= '0;
			th_s[0]  <= th0;
			neg_s[0] <= neg0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				if (!th_s[i][33]) begin
					x_s[i+1]  <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1]  <= y_s[i] + (x_s[i] >>> i);
					th_s[i+1] <= th_s[i] - atan_entry(i);
				end else begin
					x_s[i+1]  <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1]  <= y_s[i] - (x_s[i] >>> i);
					th_s[i+1] <= th_s[i] + atan_entry(i);
				end
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	logic signed [33:0] xf, yf, xr, yr;
	always_comb begin
		xf = neg_s[N] ? -x_s[N] : x_s[N];
		yf = neg_s[N] ? -y_s[N] : y_s[N];
		xr = (xf + (34'sd1 <<< (SH - 1))) >>> SH;
		yr = (yf + (34'sd1 <<< (SH - 1))) >>> SH;
	end
	assign cos_o = xr[TRIG_FRAC_BITS+1:0];
	assign sin_o = yr[TRIG_FRAC_BITS+1:0];
endmodule

// File: sv/tjfk_combine.sv
// Link-length arithmetic: products, radius and height, the yaw rotation, then the offset and clamp.
// Depends on tjfk_pkg for the link register struct.
module tjfk_combine #(
	parameter int TRIG_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             en,
	input  tjfk_pkg::links_t                 links,
	input  logic signed [TRIG_FRAC_BITS+1:0] sa,
	input  logic signed [TRIG_FRAC_BITS+1:0] ca,
	input  logic signed [TRIG_FRAC_BITS+1:0] sb,
	input  logic signed [TRIG_FRAC_BITS+1:0] cb,
	input  logic signed [TRIG_FRAC_BITS+1:0] ss,
	input  logic signed [TRIG_FRAC_BITS+1:0] cs,
	output logic [23:0]                      pos_x,
	output logic [23:0]                      pos_y,
	output logic [23:0]                      pos_z
);
	import tjfk_pkg::*;
	localparam int F = TRIG_FRAC_BITS;
	localparam int W = F + 20;
	localparam int PW = 2 * (F + 2) + 24;
	localparam int RS = F - 4;

	// products, one multiplier each, plus the shifted l2 and l3+l4 terms
	logic signed [W-1:0] p5s_s1, p6c_s1, p5c_s1, p6s_s1, l2t_s1, l34_s1;
	logic signed [F+1:0] sa_s1, ca_s1, sa_s2, ca_s2;
	logic [15:0] l1_s1, l1_s2, l1_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			p5s_s1 <= W'($signed({1'b0, links.l5}) * sb);
			p6c_s1 <= W'($signed({1'b0, links.l6}) * cs);
			p5c_s1 <= W'($signed({1'b0, links.l5}) * cb);
			p6s_s1 <= W'($signed({1'b0, links.l6}) * ss);
			l2t_s1 <= W'($signed({1'b0, links.l2})) <<< F;
			l34_s1 <= W'($signed({2'b0, links.l3} + {2'b0, links.l4})) <<< F;
			sa_s1 <= sa;
			ca_s1 <= ca;
			l1_s1 <= links.l1;
		end
	end

	logic signed [W-1:0] r, zf;
	logic signed [W-1:0] r16_s2, z_s2;
	always_comb begin
		r  = p5s_s1 + p6c_s1 - l2t_s1;
		zf = p5c_s1 - p6s_s1 + l34_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			r16_s2 <= (r + (W'(1) <<< (RS - 1))) >>> RS;
			z_s2   <= (zf + (W'(1) <<< (RS - 1))) >>> RS;
			sa_s2  <= sa_s1;
			ca_s2  <= ca_s1;
			l1_s2  <= l1_s1;
		end
	end

	logic signed [PW-1:0] px_s3, py_s3;
	logic signed [W-1:0] z_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			px_s3 <= PW'($signed(r16_s2[23:0]) * ca_s2);
			py_s3 <= PW'($signed(r16_s2[23:0]) * sa_s2);
			z_s3  <= z_s2;
			l1_s3 <= l1_s2;
		end
	end

	function automatic logic [23:0] clamp(input logic signed [PW-1:0] v);
		logic [23:0] o;
		if (v > PW'(24'sh7FFFFF))
			o = 24'h7FFFFF;
		else if (v < -PW'(25'sh800000))
			o = 24'h800000;
		else
			o = v[23:0];
		return o;
	endfunction

	logic signed [PW-1:0] xr, yr, zr;
	always_comb begin
		xr = ((px_s3 + (PW'(1) <<< (F - 1))) >>> F)
			- (PW'($signed({1'b0, l1_s3})) <<< 4);
		yr = (py_s3 + (PW'(1) <<< (F - 1))) >>> F;
		zr = PW'(z_s3);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pos_x <= clamp(xr);
			pos_y <= clamp(yr);
			pos_z <= clamp(zr);
		end
	end
endmodule

// File: sv/tjfk_checker.sv
// Port-level checker for the forward kinematics block, bound to the top level.
// Uses the macros in assert_macros.svh.
`include "assert_macros.svh"
module tjfk_assert_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic        cfg_ready
);
	`ASSERT_CLK(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped")
	`ASSERT_CLK(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed")
	`ASSERT_CLK(a_ready_free, !m_tvalid |-> s_tready, "stalled while output empty")
	`ASSERT_ALWAYS(a_rst_empty, !arst_n ##1 arst_n |-> !m_tvalid, "valid out of reset")
	`ASSERT_CLK(a_cfg, cfg_ready, "config port not ready")
endmodule

bind three_joint_arm_forward_kinematics tjfk_assert_checker u_chk (.*);
